// File: rtl/wfr_pkg.sv
// Package for the word frame receiver with XOR check.
// Holds the sizes, constants and the structs passed between the front end,
// the descriptor queue and the drain back end. No dependencies.
package wfr_pkg;

  localparam int FRAME_WORDS = 64;
  localparam int IDX_W = $clog2(FRAME_WORDS);
  localparam int POS_W = IDX_W + 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int WORD_W = 16;
  localparam int FRAME_OVERHEAD = 3;
  localparam logic [WORD_W-1:0] CHECK_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] HEADER_RESET = 16'hAA55;

  typedef struct packed {
    logic bank;
    logic [IDX_W-1:0] len;
  } desc_t;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

// File: rtl/wfr_front.sv
// Front end: header detection, length capture, payload store writes and
// the running XOR check. Owns the two store banks' busy flags.
// Depends on wfr_pkg.
module wfr_front import wfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WORD_W-1:0] header_word,
  input  logic              link_valid,
  output logic              link_ready,
  input  logic [WORD_W-1:0] link_word,
  input  logic              q_ready,
  output logic              q_push,
  output desc_t             q_desc,
  output store_wr_t         store_wr,
  input  bank_rel_t         bank_rel
);

  logic [WORD_W-1:0] header_reg;
  logic [POS_W-1:0]  write_position, write_position_next, pos_inc;
  logic [WORD_W-1:0] expected_length, expected_length_next;
  logic [WORD_W-1:0] running_check, running_check_next;
  logic              bank, bank_next;
  logic [1:0]        busy, busy_next;
  logic              accept;
  logic [IDX_W-1:0]  store_idx;

  assign cfg_ready  = 1'b1;
  assign link_ready = !busy[bank] && q_ready;
  assign accept     = link_valid && link_ready;
  assign pos_inc    = write_position + POS_W'(1);
  assign store_idx  = IDX_W'(write_position - POS_W'(2));

  always_comb begin
    write_position_next  = write_position;
    expected_length_next = expected_length;
    running_check_next   = running_check;
    bank_next            = bank;
    busy_next            = busy;
    store_wr             = '0;
    q_push               = 1'b0;
    q_desc               = '0;
    if (bank_rel.en) begin
      busy_next[bank_rel.bank] = 1'b0;
    end
    if (accept) begin
      if (write_position == '0) begin
        if (link_word == header_reg) begin
          write_position_next = POS_W'(1);
          running_check_next  = CHECK_INIT;
        end
      end else if (write_position == POS_W'(1)) begin
        expected_length_next = link_word;
        write_position_next  = POS_W'(2);
      end else if (write_position >= POS_W'(FRAME_WORDS)) begin
        write_position_next = '0;
        running_check_next  = CHECK_INIT;
      end else begin
        store_wr.en         = 1'b1;
        store_wr.addr       = {bank, store_idx};
        store_wr.data       = link_word;
        write_position_next = pos_inc;
        if ((WORD_W + 1)'(pos_inc) != ({1'b0, expected_length} + (WORD_W + 1)'(FRAME_OVERHEAD)))
        begin
          running_check_next = running_check ^ link_word;
        end else begin
          write_position_next = '0;
          running_check_next  = CHECK_INIT;
          if (link_word == running_check) begin
            q_push          = 1'b1;
            q_desc.bank     = bank;
            q_desc.len      = expected_length[IDX_W-1:0];
            bank_next       = ~bank;
            busy_next[bank] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg      <= HEADER_RESET;
      write_position  <= '0;
      expected_length <= '0;
      running_check   <= CHECK_INIT;
      bank            <= 1'b0;
      busy            <= '0;
    end else begin
      if (cfg_valid) begin
        header_reg <= header_word;
      end
      write_position  <= write_position_next;
      expected_length <= expected_length_next;
      running_check   <= running_check_next;
      bank            <= bank_next;
      busy            <= busy_next;
    end
  end

endmodule

// File: rtl/wfr_queue.sv
// Two-entry descriptor queue between the front end and the drain back end.
// Depends on wfr_pkg.
module wfr_queue import wfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output desc_t pop_desc
);

  desc_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_desc   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/wfr_back.sv
// Drain back end: holds the two-bank payload store, reads a verified frame
// word by word and presents each result through an output register.
// Depends on wfr_pkg.
module wfr_back import wfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  store_wr_t         store_wr,
  input  logic              q_valid,
  input  desc_t             q_desc,
  output logic              q_pop,
  output bank_rel_t         bank_rel,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [WORD_W-1:0] payload_word,
  output logic [IDX_W-1:0]  word_index,
  output logic [IDX_W-1:0]  frame_length,
  output logic              last_word,
  output logic              empty_frame
);

  logic [WORD_W-1:0] mem [2 * FRAME_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic              active;
  desc_t             cur;
  logic [IDX_W-1:0]  k;
  logic              pend_valid, pend_last, pend_empty;
  logic [IDX_W-1:0]  pend_k, pend_len;
  logic              pend_move, issue, is_last, is_empty;

  assign is_empty  = (cur.len == '0);
  assign is_last   = is_empty || (k == cur.len - IDX_W'(1));
  assign pend_move = pend_valid && (!result_valid || result_ready);
  assign issue     = active && (!pend_valid || pend_move);
  assign q_pop     = !active && q_valid;
  assign bank_rel.en   = issue && is_last;
  assign bank_rel.bank = cur.bank;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    if (issue) begin
      rd_data <= mem[{cur.bank, k}];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
    end
    if (issue) begin
      pend_k     <= k;
      pend_len   <= cur.len;
      pend_last  <= is_last;
      pend_empty <= is_empty;
    end
    if (pend_move) begin
      payload_word <= pend_empty ? '0 : rd_data;
      word_index   <= pend_k;
      frame_length <= pend_len;
      last_word    <= pend_last;
      empty_frame  <= pend_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      k            <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
        k      <= '0;
      end else if (issue) begin
        if (is_last) begin
          active <= 1'b0;
        end else begin
          k <= k + IDX_W'(1);
        end
      end
      if (issue) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/word_frame_receiver_xor_check.sv
// Top level of the word frame receiver with XOR check.
// Instantiates wfr_front, wfr_queue and wfr_back; depends on wfr_pkg.
//
// The receiver takes one 16-bit link word per cycle while the store bank it is
// filling is free. A frame is a header word, a length word, the payload words
// and a check word; verified frames are handed to the drain side as a queued
// descriptor and the front switches to the other of two 64-word store banks,
// so the next frame is received while the previous one drains. Reception
// stalls only when both banks hold verified frames not yet read. The drain side
// takes a frame's descriptor, then gives one result per cycle while result_ready
// is high, via the store read and output registers. No clearing pass after reset.
module word_frame_receiver_xor_check_core import wfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WORD_W-1:0] header_word,
  input  logic              link_valid,
  output logic              link_ready,
  input  logic [WORD_W-1:0] link_word,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [WORD_W-1:0] payload_word,
  output logic [IDX_W-1:0]  word_index,
  output logic [IDX_W-1:0]  frame_length,
  output logic              last_word,
  output logic              empty_frame
);

  logic      q_push, q_ready, q_pop, q_valid;
  desc_t     push_desc, pop_desc;
  store_wr_t store_wr;
  bank_rel_t bank_rel;

  wfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .header_word (header_word),
    .link_valid  (link_valid),
    .link_ready  (link_ready),
    .link_word   (link_word),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_desc      (push_desc),
    .store_wr    (store_wr),
    .bank_rel    (bank_rel)
  );

  wfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_desc   (pop_desc)
  );

  wfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .store_wr     (store_wr),
    .q_valid      (q_valid),
    .q_desc       (pop_desc),
    .q_pop        (q_pop),
    .bank_rel     (bank_rel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .payload_word (payload_word),
    .word_index   (word_index),
    .frame_length (frame_length),
    .last_word    (last_word),
    .empty_frame  (empty_frame)
  );

endmodule

// File: rtl/wfr_checker.sv
// Port-level checker for the word frame receiver, bound to the top level.
// Depends on wfr_pkg.
module wfr_checker import wfr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input logic [WORD_W-1:0] payload_word,
  input logic [IDX_W-1:0]  word_index,
  input logic [IDX_W-1:0]  frame_length,
  input logic              last_word,
  input logic              empty_frame
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(payload_word)
      && $stable(word_index))
    else $error("Result beat changed before it was taken.");

  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && empty_frame |-> last_word && payload_word == '0
      && frame_length == '0 && word_index == '0)
    else $error("Empty frame beat has wrong fields.");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !empty_frame |-> word_index < frame_length)
    else $error("Word index outside the frame length.");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && !empty_frame |->
      last_word == (word_index + IDX_W'(1) == frame_length))
    else $error("Last word flag does not match the word index.");

endmodule

bind word_frame_receiver_xor_check_core wfr_checker u_wfr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .payload_word (payload_word),
  .word_index   (word_index),
  .frame_length (frame_length),
  .last_word    (last_word),
  .empty_frame  (empty_frame)
);

// File: sim/tb_top.sv
// Self-checking testbench for word_frame_receiver_xor_check_core.
// Holds the frame predictor and scoreboard class, the drive tasks and the result monitor.
// Depends on wfr_pkg and the RTL of the receiver only.
module tb_top;
  import wfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] payload;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  flen;
    logic              last;
    logic              empty;
  } frame_word_t;

  class frame_scoreboard;
    logic [WORD_W-1:0] hdr;
    logic [WORD_W-1:0] store [FRAME_WORDS];
    int unsigned       wpos;
    logic [WORD_W-1:0] len_word;
    logic [WORD_W-1:0] xsum;
    frame_word_t       pending [$];
    int                errors;

    function new();
      hdr = HEADER_RESET;
      wpos = 0;
      len_word = '0;
      xsum = CHECK_INIT;
      errors = 0;
    endfunction

    function void set_header(logic [WORD_W-1:0] v);
      hdr = v;
    endfunction

    function void go_idle();
      wpos = 0;
      xsum = CHECK_INIT;
    endfunction

    function void note_word(logic [WORD_W-1:0] w);
      frame_word_t r;
      int unsigned n;
      if (wpos == 0) begin
        if (w == hdr) begin
          store[0] = w;
          wpos = 1;
          xsum = CHECK_INIT;
        end
        return;
      end
      if (wpos == 1) begin
        len_word = w;
        store[1] = w;
        wpos = 2;
        return;
      end
      if (wpos >= FRAME_WORDS) begin
        go_idle();
        return;
      end
      store[wpos] = w;
      wpos++;
      if (wpos != int'(len_word) + FRAME_OVERHEAD) begin
        xsum = xsum ^ w;
        return;
      end
      if (w != xsum) begin
        go_idle();
        return;
      end
      n = 32'(len_word);
      go_idle();
      if (n == 0) begin
        r = '{payload: '0, idx: '0, flen: '0, last: 1'b1, empty: 1'b1};
        pending.push_back(r);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        r.payload = store[k + 2];
        r.idx = k[IDX_W-1:0];
        r.flen = n[IDX_W-1:0];
        r.last = (k + 1 == n);
        r.empty = 1'b0;
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frame_word_t got);
      frame_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("payload_word", want.payload, got.payload);
      compare_field("word_index", 16'(want.idx), 16'(got.idx));
      compare_field("frame_length", 16'(want.flen), 16'(got.flen));
      compare_field("last_word", 16'(want.last), 16'(got.last));
      compare_field("empty_frame", 16'(want.empty), 16'(got.empty));
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [WORD_W-1:0] header_word;
  logic              link_valid;
  logic              link_ready;
  logic [WORD_W-1:0] link_word;
  logic              result_valid;
  logic              result_ready;
  logic [WORD_W-1:0] payload_word;
  logic [IDX_W-1:0]  word_index;
  logic [IDX_W-1:0]  frame_length;
  logic              last_word;
  logic              empty_frame;

  frame_scoreboard sb;
  bit              calm;
  int              words_sent;
  int              stall_left;

  word_frame_receiver_xor_check_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .header_word  (header_word),
    .link_valid   (link_valid),
    .link_ready   (link_ready),
    .link_word    (link_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .payload_word (payload_word),
    .word_index   (word_index),
    .frame_length (frame_length),
    .last_word    (last_word),
    .empty_frame  (empty_frame)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    result_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ready = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        result_ready = 1'b0;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result('{payload: payload_word, idx: word_index, flen: frame_length,
                        last: last_word, empty: empty_frame});
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    int pause;
    if (!calm && $urandom_range(0, 3) == 0) begin
      pause = $urandom_range(1, 11);
      link_valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    link_valid = 1'b1;
    link_word = w;
    @(posedge clk);
    while (!link_ready) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic send_noise();
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    if (w == sb.hdr) w = ~w;
    send_word(w);
  endtask

  // Oversized frames fill the store and lose the word after it; that word is
  // sometimes the header, which must not open a new frame.
  task automatic send_frame(input logic [WORD_W-1:0] len, input bit corrupt);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] chk;
    chk = CHECK_INIT;
    send_word(sb.hdr);
    send_word(len);
    words_sent += 2;
    if (int'(len) > FRAME_WORDS - FRAME_OVERHEAD) begin
      repeat (FRAME_WORDS - 2) send_word(WORD_W'($urandom));
      send_word($urandom_range(0, 1) ? sb.hdr : WORD_W'($urandom));
      words_sent += FRAME_WORDS - 1;
      return;
    end
    for (int k = 0; k < int'(len); k++) begin
      w = WORD_W'($urandom);
      chk ^= w;
      send_word(w);
    end
    if (corrupt) chk ^= WORD_W'($urandom_range(1, 16'hFFFF));
    send_word(chk);
    words_sent += int'(len) + 1;
  endtask

  task automatic write_header(input logic [WORD_W-1:0] v);
    cfg_valid = 1'b1;
    header_word = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_header(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    link_valid = 1'b0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d beats never arrived, expected %h, actual none", $time,
               sb.pending.size(), sb.pending[0]);
      sb.errors++;
      sb.pending.delete();
    end
    repeat (16) @(negedge clk);
  endtask

  task automatic run_phase(input logic [WORD_W-1:0] hv, input int budget);
    int r;
    logic [WORD_W-1:0] len;
    write_header(hv);
    words_sent = 0;
    if (int'(hv) <= FRAME_WORDS - FRAME_OVERHEAD) send_frame(hv, 1'b0);
    while (words_sent < budget) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      r = $urandom_range(0, 99);
      if (r < 5) begin
        len = $urandom_range(0, 1) ? WORD_W'($urandom_range(62, 64))
                                   : WORD_W'($urandom_range(62, 16'hFFFF));
      end else if (r < 8) begin
        len = WORD_W'(FRAME_WORDS - FRAME_OVERHEAD);
      end else if (r < 20) begin
        len = WORD_W'($urandom_range(7, 60));
      end else begin
        len = WORD_W'($urandom_range(0, 6));
      end
      send_frame(len, $urandom_range(0, 4) == 0);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    header_word = HEADER_RESET;
    link_valid = 1'b0;
    link_word = '0;
    words_sent = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    send_word(16'h0000);
    send_word(16'hFFFF);
    send_frame(16'd0, 1'b0);
    send_word(sb.hdr);
    send_word(16'd1);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(sb.hdr);
    send_word(16'd1);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_frame(16'd2, 1'b1);
    send_frame(16'd3, 1'b0);
    wait_drained();

    run_phase(16'h0000, 30);
    run_phase(16'hFFFF, 30);
    run_phase(16'h0007, 30);
    run_phase(WORD_W'($urandom), 30);
    calm = 1'b1;
    run_phase(HEADER_RESET, 30);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wfr_pkg.sv
rtl/wfr_front.sv
rtl/wfr_queue.sv
rtl/wfr_back.sv
rtl/word_frame_receiver_xor_check.sv
rtl/wfr_checker.sv
sim/tb_top.sv
